[rtl/rfd_pkg.sv]
// Shared types and constants for the reply frame deframer.
package rfd_pkg;

   // Opcodes carried in the first two bytes of a frame.
   localparam logic [15:0] OP_NOTIFY = 16'd9;
   localparam logic [15:0] OP_ACK    = 16'd10;
   localparam logic [15:0] OP_ERROR  = 16'd11;

   // Referenced opcodes that select the acknowledgement layout.
   localparam logic [15:0] REF_USERS_A = 16'd4;
   localparam logic [15:0] REF_USERS_B = 16'd7;
   localparam logic [15:0] REF_STATS   = 16'd8;
   localparam logic [15:0] REF_SHORT_1 = 16'd1;
   localparam logic [15:0] REF_SHORT_2 = 16'd2;
   localparam logic [15:0] REF_SHORT_3 = 16'd3;
   localparam logic [15:0] REF_SHORT_5 = 16'd5;
   localparam logic [15:0] REF_SHORT_6 = 16'd6;

   // Byte positions within a frame (1-based).
   localparam logic [3:0] POS_MAX        = 4'd15;
   localparam logic [3:0] POS_OP_LOW     = 4'd2;
   localparam logic [3:0] POS_MODE       = 4'd3;
   localparam logic [3:0] POS_REF_LOW    = 4'd4;
   localparam logic [3:0] POS_COUNT1_LOW = 4'd6;
   localparam logic [3:0] POS_COUNT2_LOW = 4'd8;
   localparam logic [3:0] POS_COUNT3_LOW = 4'd10;
   localparam logic [3:0] POS_HIGH_LAST  = 4'd9;

   // Characters and limits.
   localparam logic [7:0]  CHAR_ZERO  = 8'h30;
   localparam logic [7:0]  CHAR_ONE   = 8'h31;
   localparam logic [7:0]  CHAR_SPACE = 8'h20;
   localparam logic [15:0] ZERO_COUNT_MAX = 16'hffff;
   localparam logic [15:0] TEXT_END_ZEROS = 16'd2;

   // Message kind codes.
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_NOTIFY = 2'd1;
   localparam logic [1:0] KIND_ACK    = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   // Notification mode codes.
   localparam logic [1:0] MODE_PRIVATE = 2'd0;
   localparam logic [1:0] MODE_PUBLIC  = 2'd1;
   localparam logic [1:0] MODE_NEITHER = 2'd2;

   // One result item.
   typedef struct packed {
      logic               frame_done;
      logic [1:0]         msg_kind;
      logic [1:0]         notify_mode;
      logic signed [15:0] ref_opcode;
      logic signed [15:0] users_or_posts;
      logic signed [15:0] followers_out;
      logic signed [15:0] following_out;
      logic               text_valid;
      logic [7:0]         text_byte;
   } rfd_result_type;

endpackage

[rtl/rfd_step.sv]
// Frame state registers and the per-byte decode that produces one result.
module rfd_step
   import rfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step_en,
   input  logic [7:0]     in_byte,
   output rfd_result_type result
);

   logic [3:0]  byte_position_ff, byte_position_in;
   logic [15:0] frame_opcode_ff, frame_opcode_in;
   logic [7:0]  pending_high_ff, pending_high_in;
   logic [15:0] ref_code_ff, ref_code_in;
   logic [15:0] user_count_ff, user_count_in;
   logic [15:0] post_count_ff, post_count_in;
   logic [15:0] follower_count_ff, follower_count_in;
   logic [15:0] zero_count_ff, zero_count_in;
   logic [1:0]  mode_seen_ff, mode_seen_in;

   logic [3:0]  pos;
   logic [15:0] joined;
   logic [15:0] zero_count_inc;
   logic [7:0]  text_shown;
   logic        ref_short;
   logic        end_frame;

   // Position and joined word used by every frame type, plus zero counting for text.
   assign pos            = (byte_position_ff == POS_MAX) ? POS_MAX : byte_position_ff + 4'd1;
   assign joined         = {pending_high_ff, in_byte};
   assign zero_count_inc = ((in_byte == 8'd0) && (zero_count_ff != ZERO_COUNT_MAX))
                           ? zero_count_ff + 16'd1 : zero_count_ff;
   assign text_shown     = (in_byte == 8'd0) ? CHAR_SPACE : in_byte;
   assign ref_short      = (joined == REF_SHORT_1) || (joined == REF_SHORT_2) ||
                           (joined == REF_SHORT_3) || (joined == REF_SHORT_5) ||
                           (joined == REF_SHORT_6);

   // Decode of one byte against the current frame state.
   always_comb begin
      byte_position_in  = pos;
      frame_opcode_in   = frame_opcode_ff;
      pending_high_in   = pending_high_ff;
      ref_code_in       = ref_code_ff;
      user_count_in     = user_count_ff;
      post_count_in     = post_count_ff;
      follower_count_in = follower_count_ff;
      zero_count_in     = zero_count_ff;
      mode_seen_in      = mode_seen_ff;
      end_frame         = 1'b0;

      result                = '0;
      result.notify_mode    = MODE_NEITHER;

      if (pos == POS_OP_LOW) begin
         frame_opcode_in = joined;
      end else if (pos[0] && (pos <= POS_HIGH_LAST)) begin
         pending_high_in = in_byte;
      end

      if (pos > POS_OP_LOW) begin
         unique case (frame_opcode_ff)
            OP_NOTIFY: begin
               if (pos == POS_MODE) begin
                  if (in_byte == CHAR_ZERO) begin
                     mode_seen_in = MODE_PRIVATE;
                  end else if (in_byte == CHAR_ONE) begin
                     mode_seen_in = MODE_PUBLIC;
                  end else begin
                     mode_seen_in = MODE_NEITHER;
                  end
               end else begin
                  zero_count_in     = zero_count_inc;
                  result.text_valid = 1'b1;
                  if (zero_count_inc == TEXT_END_ZEROS) begin
                     result.text_byte   = in_byte;
                     result.frame_done  = 1'b1;
                     result.msg_kind    = KIND_NOTIFY;
                     result.notify_mode = mode_seen_ff;
                     end_frame          = 1'b1;
                  end else begin
                     result.text_byte = text_shown;
                  end
               end
            end
            OP_ERROR: begin
               if (pos == POS_REF_LOW) begin
                  ref_code_in       = joined;
                  result.frame_done = 1'b1;
                  result.msg_kind   = KIND_ERROR;
                  result.ref_opcode = joined;
                  end_frame         = 1'b1;
               end
            end
            OP_ACK: begin
               if (pos == POS_REF_LOW) begin
                  ref_code_in = joined;
                  if (ref_short) begin
                     result.frame_done = 1'b1;
                     result.msg_kind   = KIND_ACK;
                     result.ref_opcode = joined;
                     end_frame         = 1'b1;
                  end
               end else if ((pos > POS_REF_LOW) &&
                            ((ref_code_ff == REF_USERS_A) || (ref_code_ff == REF_USERS_B))) begin
                  // User list: count first, then zero-terminated names.
                  if (pos == POS_COUNT1_LOW) begin
                     user_count_in = joined;
                  end else if (pos > POS_COUNT1_LOW) begin
                     zero_count_in     = zero_count_inc;
                     result.text_valid = 1'b1;
                     if ((zero_count_inc != 16'd0) && !user_count_ff[15] &&
                         (zero_count_inc == user_count_ff)) begin
                        result.text_byte      = in_byte;
                        result.frame_done     = 1'b1;
                        result.msg_kind       = KIND_ACK;
                        result.ref_opcode     = ref_code_ff;
                        result.users_or_posts = user_count_ff;
                        end_frame             = 1'b1;
                     end else begin
                        result.text_byte = text_shown;
                     end
                  end
               end else if ((pos > POS_REF_LOW) && (ref_code_ff == REF_STATS)) begin
                  // Statistics: three 16-bit counts.
                  if (pos == POS_COUNT1_LOW) begin
                     post_count_in = joined;
                  end else if (pos == POS_COUNT2_LOW) begin
                     follower_count_in = joined;
                  end else if (pos == POS_COUNT3_LOW) begin
                     result.frame_done     = 1'b1;
                     result.msg_kind       = KIND_ACK;
                     result.ref_opcode     = ref_code_ff;
                     result.users_or_posts = post_count_ff;
                     result.followers_out  = follower_count_ff;
                     result.following_out  = joined;
                     end_frame             = 1'b1;
                  end
               end
            end
            default: begin
               // Unknown opcode: the frame never ends.
            end
         endcase
      end

      if (end_frame) begin
         byte_position_in = 4'd0;
         zero_count_in    = 16'd0;
         frame_opcode_in  = 16'd0;
         mode_seen_in     = MODE_NEITHER;
      end
   end

   // State registers advance once per accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff  <= 4'd0;
         frame_opcode_ff   <= 16'd0;
         pending_high_ff   <= 8'd0;
         ref_code_ff       <= 16'd0;
         user_count_ff     <= 16'd0;
         post_count_ff     <= 16'd0;
         follower_count_ff <= 16'd0;
         zero_count_ff     <= 16'd0;
         mode_seen_ff      <= MODE_NEITHER;
      end else if (step_en) begin
         byte_position_ff  <= byte_position_in;
         frame_opcode_ff   <= frame_opcode_in;
         pending_high_ff   <= pending_high_in;
         ref_code_ff       <= ref_code_in;
         user_count_ff     <= user_count_in;
         post_count_ff     <= post_count_in;
         follower_count_ff <= follower_count_in;
         zero_count_ff     <= zero_count_in;
         mode_seen_ff      <= mode_seen_in;
      end
   end

   // A completed frame returns the position to the start.
   a_done_restarts: assert property (@(posedge clock) disable iff (reset)
      (step_en && result.frame_done) |=> (byte_position_ff == 4'd0))
      else $error("frame completion did not restart the byte position");

   // The opcode is not known before its low byte has arrived.
   a_opcode_clear: assert property (@(posedge clock) disable iff (reset)
      (byte_position_ff < POS_OP_LOW) |-> (frame_opcode_ff == 16'd0))
      else $error("opcode set before its second byte");

   // Zeros are only counted inside a frame's text.
   a_zero_count_idle: assert property (@(posedge clock) disable iff (reset)
      (byte_position_ff == 4'd0) |-> (zero_count_ff == 16'd0))
      else $error("zero count left over at frame start");

endmodule

[rtl/rfd_out_stage.sv]
// Result register with valid flag that decouples the two channels.
module rfd_out_stage
   import rfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  rfd_result_type load_data,
   input  logic           out_stall,
   output logic           out_valid,
   output logic           hold,
   output rfd_result_type out_data
);

   logic           valid_ff, valid_in;
   rfd_result_type data_ff;

   // The register holds only while a result waits under stall.
   assign hold      = valid_ff && out_stall;
   assign valid_in  = load || hold;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload loads on every transfer into the stage.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   // A loaded result is presented in the next cycle.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded result not presented");

   // The stage never loads over a result that is still held.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      hold |-> !load)
      else $error("held result overwritten");

   // A held result stays unchanged.
   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      hold |=> $stable(data_ff))
      else $error("held result changed");

endmodule

[rtl/reply_frame_deframer.sv]
// Top level of the reply frame deframer: byte decode plus result register.
// The block takes one reply byte per transfer and returns exactly one result
// per byte, one byte per clock sustained. A byte accepted at one clock edge
// has its result on the rsp_ port from the next cycle on: the decode of the
// byte against the frame state is combinational and lands in a single result
// register. req_stall is raised only while that register holds a result that
// the consumer is stalling, so the block runs at full rate whenever the
// result side takes its transfers. Results with rsp_frame_done high carry the
// decoded frame fields; text bytes of notifications and user lists arrive
// with rsp_text_valid high, one per input byte.
module reply_frame_deframer
   import rfd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_in_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_frame_done,
   output logic [1:0]         rsp_msg_kind,
   output logic [1:0]         rsp_notify_mode,
   output logic signed [15:0] rsp_ref_opcode,
   output logic signed [15:0] rsp_users_or_posts,
   output logic signed [15:0] rsp_followers_out,
   output logic signed [15:0] rsp_following_out,
   output logic               rsp_text_valid,
   output logic [7:0]         rsp_text_byte
);

   logic           advance;
   logic           hold;
   rfd_result_type step_result;
   rfd_result_type out_data;

   // A byte transfers when offered and the result register can take it.
   assign req_stall = hold;
   assign advance   = req_valid && !hold;

   rfd_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .in_byte (req_in_byte),
      .result  (step_result)
   );

   rfd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_data (step_result),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .hold      (hold),
      .out_data  (out_data)
   );

   // Result fields onto their ports.
   assign rsp_frame_done     = out_data.frame_done;
   assign rsp_msg_kind       = out_data.msg_kind;
   assign rsp_notify_mode    = out_data.notify_mode;
   assign rsp_ref_opcode     = out_data.ref_opcode;
   assign rsp_users_or_posts = out_data.users_or_posts;
   assign rsp_followers_out  = out_data.followers_out;
   assign rsp_following_out  = out_data.following_out;
   assign rsp_text_valid     = out_data.text_valid;
   assign rsp_text_byte      = out_data.text_byte;

endmodule

[tb/sv/tb_reply_frame_deframer.sv]
// Self-checking testbench for the reply frame deframer with a built-in byte decoder.
module tb_reply_frame_deframer;
   import rfd_pkg::*;

   localparam int IDLE_LIMIT   = 4000;
   localparam int SETTLE_TICKS = 20;
   localparam int RANDOM_BYTES = 700;

   // One queued request byte; drain_first holds it back until all results are in.
   typedef struct {
      logic [7:0] value;
      bit         drain_first;
   } tx_byte_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_in_byte = 8'd0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_frame_done;
   logic [1:0]         rsp_msg_kind;
   logic [1:0]         rsp_notify_mode;
   logic signed [15:0] rsp_ref_opcode;
   logic signed [15:0] rsp_users_or_posts;
   logic signed [15:0] rsp_followers_out;
   logic signed [15:0] rsp_following_out;
   logic               rsp_text_valid;
   logic [7:0]         rsp_text_byte;

   tx_byte_type    pending_bytes[$];
   rfd_result_type expected_replies[$];
   bit             hold_for_drain = 1'b0;
   bit             byte_taken = 1'b0;
   bit             wind_down = 1'b0;
   int             mismatch_count = 0;
   int             idle_cycles = 0;
   int             burst_left = 0;
   int             gap_left = 0;
   int             stall_left = 0;
   int             open_left = 0;

   // Decoder state, at its reset values.
   logic [3:0]  frame_pos = 4'd0;
   logic [15:0] frame_code = 16'd0;
   logic [7:0]  high_byte = 8'd0;
   logic [15:0] ref_code = 16'd0;
   logic [15:0] user_total = 16'd0;
   logic [15:0] post_total = 16'd0;
   logic [15:0] follower_total = 16'd0;
   logic [15:0] zeros_seen = 16'd0;
   logic [1:0]  mode_kept = MODE_NEITHER;

   reply_frame_deframer u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_msg_kind       (rsp_msg_kind),
      .rsp_notify_mode    (rsp_notify_mode),
      .rsp_ref_opcode     (rsp_ref_opcode),
      .rsp_users_or_posts (rsp_users_or_posts),
      .rsp_followers_out  (rsp_followers_out),
      .rsp_following_out  (rsp_following_out),
      .rsp_text_valid     (rsp_text_valid),
      .rsp_text_byte      (rsp_text_byte)
   );

   // Clock generation.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // A finished frame returns the position, zero tally, opcode and mode to idle.
   function automatic void close_frame();
      frame_pos  = 4'd0;
      zeros_seen = 16'd0;
      frame_code = 16'd0;
      mode_kept  = MODE_NEITHER;
   endfunction

   // Zero bytes in text are counted, saturating at the top of the counter.
   function automatic void tally_zero(logic [7:0] b);
      if (b == 8'd0 && zeros_seen != ZERO_COUNT_MAX) begin
         zeros_seen = zeros_seen + 16'd1;
      end
   endfunction

   // Advances the frame state by one byte and returns the result it produces.
   function automatic rfd_result_type decode_reply_byte(logic [7:0] b);
      rfd_result_type r;
      logic [3:0]     pos;
      r = '0;
      r.notify_mode = MODE_NEITHER;
      pos = (frame_pos < POS_MAX) ? frame_pos + 4'd1 : POS_MAX;
      frame_pos = pos;

      // Odd positions up to nine latch the high byte of the next word.
      if (pos == POS_OP_LOW) begin
         frame_code = {high_byte, b};
      end else if (pos[0] && pos <= POS_HIGH_LAST) begin
         high_byte = b;
      end

      if (pos >= POS_OP_LOW) begin
         if (frame_code == OP_NOTIFY) begin
            if (pos == POS_MODE) begin
               mode_kept = (b == CHAR_ZERO) ? MODE_PRIVATE :
                           (b == CHAR_ONE)  ? MODE_PUBLIC : MODE_NEITHER;
            end
            if (pos > POS_MODE) begin
               tally_zero(b);
               r.text_valid = 1'b1;
               if (zeros_seen == TEXT_END_ZEROS) begin
                  r.text_byte   = b;
                  r.frame_done  = 1'b1;
                  r.msg_kind    = KIND_NOTIFY;
                  r.notify_mode = mode_kept;
                  close_frame();
               end else begin
                  r.text_byte = (b == 8'd0) ? CHAR_SPACE : b;
               end
            end
         end else if (frame_code == OP_ERROR) begin
            if (pos == POS_REF_LOW) begin
               ref_code     = {high_byte, b};
               r.frame_done = 1'b1;
               r.msg_kind   = KIND_ERROR;
               r.ref_opcode = ref_code;
               close_frame();
            end
         end else if (frame_code == OP_ACK) begin
            if (pos == POS_REF_LOW) begin
               ref_code = {high_byte, b};
               if (ref_code == REF_SHORT_1 || ref_code == REF_SHORT_2 ||
                   ref_code == REF_SHORT_3 || ref_code == REF_SHORT_5 ||
                   ref_code == REF_SHORT_6) begin
                  r.frame_done = 1'b1;
                  r.msg_kind   = KIND_ACK;
                  r.ref_opcode = ref_code;
                  close_frame();
               end
            end else if (pos > POS_REF_LOW &&
                         (ref_code == REF_USERS_A || ref_code == REF_USERS_B)) begin
               if (pos == POS_COUNT1_LOW) begin
                  user_total = {high_byte, b};
               end
               // The user list ends once the zero tally meets a positive count.
               if (pos > POS_COUNT1_LOW) begin
                  tally_zero(b);
                  r.text_valid = 1'b1;
                  if (zeros_seen != 16'd0 && !user_total[15] &&
                      zeros_seen == user_total) begin
                     r.text_byte      = b;
                     r.frame_done     = 1'b1;
                     r.msg_kind       = KIND_ACK;
                     r.ref_opcode     = ref_code;
                     r.users_or_posts = user_total;
                     close_frame();
                  end else begin
                     r.text_byte = (b == 8'd0) ? CHAR_SPACE : b;
                  end
               end
            end else if (pos > POS_REF_LOW && ref_code == REF_STATS) begin
               if (pos == POS_COUNT1_LOW) begin
                  post_total = {high_byte, b};
               end else if (pos == POS_COUNT2_LOW) begin
                  follower_total = {high_byte, b};
               end else if (pos == POS_COUNT3_LOW) begin
                  r.frame_done     = 1'b1;
                  r.msg_kind       = KIND_ACK;
                  r.ref_opcode     = ref_code;
                  r.users_or_posts = post_total;
                  r.followers_out  = follower_total;
                  r.following_out  = {high_byte, b};
                  close_frame();
               end
            end
         end
      end
      return r;
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Stimulus helpers that append bytes to the request queue.
   task automatic queue_byte(input logic [7:0] value);
      tx_byte_type t;
      t.value = value;
      t.drain_first = hold_for_drain;
      hold_for_drain = 1'b0;
      pending_bytes = {pending_bytes, t};
   endtask

   task automatic queue_word(input logic [15:0] w);
      queue_byte(w[15:8]);
      queue_byte(w[7:0]);
   endtask

   task automatic queue_text_run(input int len);
      repeat (len) queue_byte(8'($urandom_range(1, 255)));
   endtask

   task automatic queue_notification(input logic [7:0] mode_char, input int lead,
                                     input int tail);
      queue_word(OP_NOTIFY);
      queue_byte(mode_char);
      queue_text_run(lead);
      queue_byte(8'd0);
      queue_text_run(tail);
      queue_byte(8'd0);
   endtask

   task automatic queue_error(input logic [15:0] code);
      queue_word(OP_ERROR);
      queue_word(code);
   endtask

   task automatic queue_user_list(input logic [15:0] code, input int count);
      queue_word(OP_ACK);
      queue_word(code);
      queue_word(16'(count));
      repeat (count) begin
         queue_text_run($urandom_range(0, 6));
         queue_byte(8'd0);
      end
   endtask

   task automatic queue_stats(input logic [15:0] posts, input logic [15:0] fols,
                              input logic [15:0] fings);
      queue_word(OP_ACK);
      queue_word(REF_STATS);
      queue_word(posts);
      queue_word(fols);
      queue_word(fings);
   endtask

   // Monitor: checks each result transfer, then predicts each request transfer.
   always @(posedge clock) begin : monitor
      rfd_result_type want;
      rfd_result_type predicted;
      bit             result_taken;
      result_taken = 1'b0;
      byte_taken = 1'b0;
      if (!reset) begin
         result_taken = rsp_valid && !rsp_stall;
         if (result_taken) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: result transfer with nothing expected", $time);
               mismatch_count++;
            end else begin
               want = expected_replies.pop_front();
               check_field("frame_done", 16'(want.frame_done), 16'(rsp_frame_done));
               check_field("msg_kind", 16'(want.msg_kind), 16'(rsp_msg_kind));
               check_field("notify_mode", 16'(want.notify_mode), 16'(rsp_notify_mode));
               check_field("ref_opcode", want.ref_opcode, rsp_ref_opcode);
               check_field("users_or_posts", want.users_or_posts, rsp_users_or_posts);
               check_field("followers_out", want.followers_out, rsp_followers_out);
               check_field("following_out", want.following_out, rsp_following_out);
               check_field("text_valid", 16'(want.text_valid), 16'(rsp_text_valid));
               check_field("text_byte", 16'(want.text_byte), 16'(rsp_text_byte));
            end
         end
         byte_taken = req_valid && !req_stall;
         if (byte_taken) begin
            predicted = decode_reply_byte(req_in_byte);
            expected_replies = {expected_replies, predicted};
            void'(pending_bytes.pop_front());
         end
      end

      // Watchdog on cycles without any transfer.
      if (result_taken || byte_taken || reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles == IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Driver: presents queued bytes in bursts separated by random gaps.
   always @(negedge clock) begin : driver
      logic       next_valid;
      logic [7:0] next_byte;
      next_valid = req_valid;
      next_byte  = req_in_byte;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || byte_taken) begin
         next_valid = 1'b0;
         if (gap_left != 0) begin
            gap_left--;
         end else if (pending_bytes.size() != 0 &&
                      (!pending_bytes[0].drain_first || expected_replies.size() == 0)) begin
            next_valid = 1'b1;
            next_byte  = pending_bytes[0].value;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 48);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
               burst_left--;
            end
         end
      end
      req_valid   <= next_valid;
      req_in_byte <= next_byte;
   end

   // Receiver: alternates stall runs and open runs of random length.
   always @(negedge clock) begin : receiver
      if (wind_down) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0 && open_left == 0) begin
            stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            open_left  = $urandom_range(1, ($urandom_range(0, 1) != 0) ? 3 : 40);
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            open_left--;
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus, reset and end of test.
   initial begin
      int          frame_index;
      int          tail_kind;
      logic [15:0] word_val;
      logic [7:0]  mode_char;
      frame_index = 0;

      // Directed frames: field extremes and the shortest endings.
      queue_error(16'hffff);
      queue_word(OP_ACK);
      queue_word(REF_SHORT_1);
      queue_stats(16'h8000, 16'h7fff, 16'hffff);
      queue_notification(CHAR_ONE, 0, 0);
      queue_user_list(REF_USERS_A, 1);

      // Random well-formed frames with random content.
      while (pending_bytes.size() < RANDOM_BYTES) begin
         frame_index++;
         if (frame_index % 40 == 20) begin
            hold_for_drain = 1'b1;
         end
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               case ($urandom_range(0, 3))
                  0: mode_char = CHAR_ZERO;
                  1: mode_char = CHAR_ONE;
                  2: mode_char = 8'd0;
                  default: mode_char = 8'($urandom_range(0, 255));
               endcase
               queue_notification(mode_char,
                  ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4),
                  ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4));
            end
            3, 4: begin
               case ($urandom_range(0, 4))
                  0: word_val = 16'h8000;
                  1: word_val = 16'h7fff;
                  default: word_val = 16'($urandom);
               endcase
               queue_error(word_val);
            end
            5: begin
               case ($urandom_range(0, 4))
                  0: word_val = REF_SHORT_1;
                  1: word_val = REF_SHORT_2;
                  2: word_val = REF_SHORT_3;
                  3: word_val = REF_SHORT_5;
                  default: word_val = REF_SHORT_6;
               endcase
               queue_word(OP_ACK);
               queue_word(word_val);
            end
            6, 7: begin
               queue_user_list(($urandom_range(0, 1) != 0) ? REF_USERS_A : REF_USERS_B,
                  ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 5));
            end
            default: begin
               queue_stats(16'($urandom), 16'($urandom), 16'($urandom));
            end
         endcase
      end

      // A frame that never ends can only come last, since reset is not repeated.
      tail_kind = $urandom_range(0, 2);
      if (tail_kind == 0) begin
         // Unknown opcode.
         do word_val = 16'($urandom);
         while (word_val inside {OP_NOTIFY, OP_ACK, OP_ERROR});
         queue_word(word_val);
         repeat (40) queue_byte(8'($urandom_range(0, 255)));
      end else if (tail_kind == 1) begin
         // Acknowledgement of an unknown opcode.
         queue_word(OP_ACK);
         do word_val = 16'($urandom);
         while (word_val >= REF_SHORT_1 && word_val <= REF_STATS);
         queue_word(word_val);
         repeat (40) queue_byte(8'($urandom_range(0, 255)));
      end else begin
         // User list with a zero or negative count, which never ends.
         queue_word(OP_ACK);
         queue_word(($urandom_range(0, 1) != 0) ? REF_USERS_A : REF_USERS_B);
         case ($urandom_range(0, 2))
            0: word_val = 16'd0;
            1: word_val = 16'h8000;
            default: word_val = 16'($urandom_range(16'h8000, 16'hffff));
         endcase
         queue_word(word_val);
         repeat (20) queue_byte(8'd0);
         repeat (20) queue_byte(8'($urandom_range(0, 255)));
      end

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Wait for every byte to be taken and every result to be checked.
      while (pending_bytes.size() != 0 || expected_replies.size() != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
      wind_down = 1'b1;
      repeat (SETTLE_TICKS) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
